FILE: design/bbs_pkg.sv
// ----------------------------------------------------------------------------
// Backtracking byte stream package
// Shared sizes, request and status codes, and the control bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package bbs_pkg;

  // Store depths and the widths that follow from them.
  localparam int HIST_DEPTH = 256;
  localparam int CP_DEPTH   = 16;
  localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int LEN_W      = $clog2(HIST_DEPTH + 1);
  localparam int CP_AW      = (CP_DEPTH > 1) ? $clog2(CP_DEPTH) : 1;
  localparam int CNT_W      = $clog2(CP_DEPTH + 1);

  // Field widths of the channels.
  localparam int REQ_W  = 2;
  localparam int BYTE_W = 8;
  localparam int STAT_W = 2;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_BEGIN = 2'd1;
  localparam logic [REQ_W-1:0] REQ_END   = 2'd2;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK            = 2'd0;
  localparam logic [STAT_W-1:0] ST_CAPACITY      = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_CHECKPOINT = 2'd2;
  localparam logic [STAT_W-1:0] ST_SOURCE_FAILED = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the request and read the history memory
    logic execute;  // apply the request and load the result register
  } bbs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_free;  // result register is empty or is being taken
  } bbs_sts_t;

endpackage

FILE: design/bbs_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one request of the byte stream.
// ----------------------------------------------------------------------------
interface bbs_req_if;
  import bbs_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic              commit;
  logic [BYTE_W-1:0] source_byte;
  logic              source_error;

  modport source (output valid, output req_type, output commit,
                  output source_byte, output source_error, input ready);
  modport sink   (input valid, input req_type, input commit,
                  input source_byte, input source_error, output ready);
endinterface

FILE: design/bbs_rsp_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries the result of one request.
// ----------------------------------------------------------------------------
interface bbs_rsp_if;
  import bbs_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [BYTE_W-1:0] data_byte;
  logic              source_taken;

  modport source (output valid, output status, output data_byte,
                  output source_taken, input ready);
  modport sink   (input valid, input status, input data_byte,
                  input source_taken, output ready);
endinterface

FILE: design/bbs_ctrl.sv
// ----------------------------------------------------------------------------
// Backtracking byte stream controller
// Two-state sequencer: accept a request, then execute it once the result
// register has room.
// ----------------------------------------------------------------------------
module bbs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bbs_pkg::bbs_sts_t sts,
  output bbs_pkg::bbs_cmd_t cmd
);
  import bbs_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Handshake and commands.
  assign in_ready    = (state_r == S_IDLE);
  assign cmd.capture = (state_r == S_IDLE) && in_valid;
  assign cmd.execute = (state_r == S_EXEC) && sts.slot_free;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (sts.slot_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: design/bbs_datapath.sv
// ----------------------------------------------------------------------------
// Backtracking byte stream datapath
// Request registers, history memory, checkpoint stack, stream pointers and
// the result register.
// ----------------------------------------------------------------------------
module bbs_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bbs_pkg::bbs_cmd_t            cmd,
  output bbs_pkg::bbs_sts_t            sts,
  input  logic [bbs_pkg::REQ_W-1:0]    in_req_type,
  input  logic                         in_commit,
  input  logic [bbs_pkg::BYTE_W-1:0]   in_source_byte,
  input  logic                         in_source_error,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bbs_pkg::STAT_W-1:0]   out_status,
  output logic [bbs_pkg::BYTE_W-1:0]   out_data_byte,
  output logic                         out_source_taken
);
  import bbs_pkg::*;

  // Captured request.
  logic [REQ_W-1:0]  req_type_r;
  logic              commit_r;
  logic [BYTE_W-1:0] src_byte_r;
  logic              src_err_r;

  // Stream state.
  logic [LEN_W-1:0]  hist_len_r, hist_len_nxt;
  logic [LEN_W-1:0]  rd_pos_r, rd_pos_nxt;
  logic [CNT_W-1:0]  cp_cnt_r, cp_cnt_nxt;
  logic [LEN_W-1:0]  cp_stack_r [CP_DEPTH];
  logic [BYTE_W-1:0] hist_mem [HIST_DEPTH];
  logic [BYTE_W-1:0] hist_rdata_r;

  // Result register.
  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [BYTE_W-1:0] out_data_r;
  logic              out_taken_r;

  // Per-request results.
  logic [STAT_W-1:0] res_status;
  logic [BYTE_W-1:0] res_data;
  logic              res_taken;
  logic              hist_we;
  logic              stk_we;
  logic [CNT_W-1:0]  cp_dec;

  assign cp_dec = cp_cnt_r - CNT_W'(1);

  // Latch the request on transfer.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_type_r <= in_req_type;
      commit_r   <= in_commit;
      src_byte_r <= in_source_byte;
      src_err_r  <= in_source_error;
    end
  end

  // History memory: read at the read position on transfer, write on record.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      hist_rdata_r <= hist_mem[rd_pos_r[HIST_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_len_r[HIST_AW-1:0]] <= src_byte_r;
    end
  end

  // Request decode and state update.
  always_comb begin
    res_status   = ST_OK;
    res_data     = '0;
    res_taken    = 1'b0;
    hist_len_nxt = hist_len_r;
    rd_pos_nxt   = rd_pos_r;
    cp_cnt_nxt   = cp_cnt_r;
    hist_we      = 1'b0;
    stk_we       = 1'b0;
    case (req_type_r)
      REQ_READ: begin
        if (rd_pos_r < hist_len_r) begin
          // Replay from history.
          res_data   = hist_rdata_r;
          rd_pos_nxt = rd_pos_r + LEN_W'(1);
        end else if (src_err_r) begin
          res_status = ST_SOURCE_FAILED;
        end else begin
          // Fresh byte, recorded while a checkpoint is open.
          res_data  = src_byte_r;
          res_taken = 1'b1;
          if (cp_cnt_r != '0) begin
            if (hist_len_r == LEN_W'(HIST_DEPTH)) begin
              res_status = ST_CAPACITY;
            end else begin
              hist_we      = cmd.execute;
              hist_len_nxt = hist_len_r + LEN_W'(1);
              rd_pos_nxt   = rd_pos_r + LEN_W'(1);
            end
          end
        end
      end
      REQ_BEGIN: begin
        if (cp_cnt_r == CNT_W'(CP_DEPTH)) begin
          res_status = ST_CAPACITY;
        end else begin
          stk_we     = cmd.execute;
          cp_cnt_nxt = cp_cnt_r + CNT_W'(1);
        end
      end
      REQ_END: begin
        if (cp_cnt_r == '0) begin
          res_status = ST_NO_CHECKPOINT;
        end else begin
          cp_cnt_nxt = cp_dec;
          if (!commit_r) rd_pos_nxt = cp_stack_r[cp_dec[CP_AW-1:0]];
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  // Checkpoint stack push.
  always_ff @(posedge clk) begin
    if (stk_we) begin
      cp_stack_r[cp_cnt_r[CP_AW-1:0]] <= rd_pos_r;
    end
  end

  // Pointers and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_len_r <= '0;
      rd_pos_r   <= '0;
      cp_cnt_r   <= '0;
    end else if (cmd.execute) begin
      hist_len_r <= hist_len_nxt;
      rd_pos_r   <= rd_pos_nxt;
      cp_cnt_r   <= cp_cnt_nxt;
    end
  end

  // Result register and its handshake.
  assign sts.slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.execute) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      out_status_r <= res_status;
      out_data_r   <= res_data;
      out_taken_r  <= res_taken;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_data_byte    = out_data_r;
  assign out_source_taken = out_taken_r;

endmodule

FILE: design/backtracking_byte_stream.sv
// ----------------------------------------------------------------------------
// Backtracking byte stream
// Byte source with a replay history and a checkpoint stack for rollback.
// ----------------------------------------------------------------------------
// On transfer the request is latched and the history memory is read at the
// read position (the memory read is registered); in the execute state that
// follows, the request is applied and the result register is loaded. A new
// request is taken as soon as the previous one has been loaded into the
// result register, even while that result still waits; the execute state
// holds only while the result register is full and stalled.
// The history and checkpoint stores need no clearing after reset.
module backtracking_byte_stream (
  input logic       clk,
  input logic       rst_n,
  bbs_req_if.sink   in_req,
  bbs_rsp_if.source out_rsp
);
  import bbs_pkg::*;

  bbs_cmd_t cmd;
  bbs_sts_t sts;

  // Sequencer.
  bbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Storage and request execution.
  bbs_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_req_type      (in_req.req_type),
    .in_commit        (in_req.commit),
    .in_source_byte   (in_req.source_byte),
    .in_source_error  (in_req.source_error),
    .out_valid        (out_rsp.valid),
    .out_ready        (out_rsp.ready),
    .out_status       (out_rsp.status),
    .out_data_byte    (out_rsp.data_byte),
    .out_source_taken (out_rsp.source_taken)
  );

endmodule

FILE: design/bbs_checker.sv
// ----------------------------------------------------------------------------
// Backtracking byte stream checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module bbs_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [bbs_pkg::STAT_W-1:0]   out_status,
  input logic [bbs_pkg::BYTE_W-1:0]   out_data_byte,
  input logic                         out_source_taken
);
  import bbs_pkg::*;

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_data_byte) && $stable(out_source_taken))
    else $error("stalled result changed");

  // One request at a time: no transfer right after a transfer.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another executes");

  // A consumed source byte only goes with ok or out of capacity.
  a_taken_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_source_taken |-> out_status == ST_OK || out_status == ST_CAPACITY)
    else $error("source taken with wrong status");

  // A source failure delivers nothing.
  a_fail_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_SOURCE_FAILED |-> out_data_byte == '0 && !out_source_taken)
    else $error("source failure delivered data");

endmodule

bind backtracking_byte_stream bbs_checker u_bbs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_req.valid),
  .in_ready         (in_req.ready),
  .out_valid        (out_rsp.valid),
  .out_ready        (out_rsp.ready),
  .out_status       (out_rsp.status),
  .out_data_byte    (out_rsp.data_byte),
  .out_source_taken (out_rsp.source_taken)
);

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// Backtracking byte stream testbench
// Drives read, begin and end requests into the byte stream and predicts every
// result with its own model of the history store, read position and checkpoint
// stack. A short directed pass covers the corner cases. Random transaction
// sequences, deep nesting and noise follow under three idling profiles.
// ----------------------------------------------------------------------------
module testbench;
  import bbs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Request code that the block ignores.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [BYTE_W-1:0] data_byte;
    logic              source_taken;
  } stream_result_t;

  // Predicts each result from its own copy of the stream state and checks
  // the results in order.
  class stream_scoreboard;
    bit [BYTE_W-1:0]  history [HIST_DEPTH];
    bit [LEN_W-1:0]   hist_len;
    bit [LEN_W-1:0]   rd_pos;
    bit [LEN_W-1:0]   checkpoints [CP_DEPTH];
    bit [CNT_W-1:0]   cp_count;
    stream_result_t   expected_results [$];
    int unsigned      mismatches;

    function int pending();
      return expected_results.size();
    endfunction

    // Work out the result of one transferred request and update the state.
    function void note_request(logic [REQ_W-1:0] kind, logic keep,
                               logic [BYTE_W-1:0] src, logic src_err);
      stream_result_t r;
      r = '0;
      r.status = ST_OK;
      case (kind)
        REQ_READ: begin
          if (rd_pos < hist_len) begin
            // Replay from the history; a source error does not matter here.
            r.data_byte = history[rd_pos[HIST_AW-1:0]];
            rd_pos++;
          end else if (src_err) begin
            r.status = ST_SOURCE_FAILED;
          end else begin
            r.data_byte    = src;
            r.source_taken = 1'b1;
            // Record only while a checkpoint is open.
            if (cp_count != 0) begin
              if (hist_len >= HIST_DEPTH) begin
                r.status = ST_CAPACITY;
              end else begin
                history[hist_len[HIST_AW-1:0]] = src;
                hist_len++;
                rd_pos++;
              end
            end
          end
        end
        REQ_BEGIN: begin
          if (cp_count >= CP_DEPTH) begin
            r.status = ST_CAPACITY;
          end else begin
            checkpoints[cp_count[CP_AW-1:0]] = rd_pos;
            cp_count++;
          end
        end
        REQ_END: begin
          if (cp_count == 0) begin
            r.status = ST_NO_CHECKPOINT;
          end else begin
            cp_count--;
            if (!keep) rd_pos = checkpoints[cp_count[CP_AW-1:0]];
          end
        end
        default: ;
      endcase
      expected_results.push_back(r);
    endfunction

    // Compare one transferred result with the oldest prediction.
    function void check_result(stream_result_t got);
      stream_result_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d data %02h taken %0d",
                   got.status, got.data_byte, got.source_taken);
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status || got.data_byte !== want.data_byte ||
          got.source_taken !== want.source_taken) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %0d/%02h/%0d, got %0d/%02h/%0d",
                   want.status, want.data_byte, want.source_taken,
                   got.status, got.data_byte, got.source_taken);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   n_sent;

  bbs_req_if req_ch ();
  bbs_rsp_if rsp_ch ();

  stream_scoreboard sb = new();

  backtracking_byte_stream u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result side stalls at random according to the current profile.
  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Watch both channels and feed every transfer to the scoreboard.
  always @(posedge clk) begin
    if (rst_n) begin
      if (req_ch.valid && req_ch.ready)
        sb.note_request(req_ch.req_type, req_ch.commit, req_ch.source_byte,
                        req_ch.source_error);
      if (rsp_ch.valid && rsp_ch.ready)
        sb.check_result({rsp_ch.status, rsp_ch.data_byte, rsp_ch.source_taken});
    end
  end

  // Present one request, with random idle cycles first, and wait for its transfer.
  task automatic send_req(input logic [REQ_W-1:0] kind, input logic keep,
                          input logic [BYTE_W-1:0] src, input logic src_err);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= kind;
    req_ch.commit       <= keep;
    req_ch.source_byte  <= src;
    req_ch.source_error <= src_err;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (kind != REQ_UNUSED) n_sent++;
  endtask

  // A read with random content; the source fails now and then.
  task automatic send_read();
    send_req(REQ_READ, 1'($urandom_range(1)), BYTE_W'($urandom_range(255)),
             $urandom_range(19) == 0);
  endtask

  // A begin or an end with random filler in the unused fields.
  task automatic send_ctl(input logic [REQ_W-1:0] kind);
    send_req(kind, 1'($urandom_range(1)), BYTE_W'($urandom_range(255)),
             1'($urandom_range(1)));
  endtask

  // Hold off the sender until every outstanding result has come back.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Random stimulus: mostly well-formed transactions, with deep nesting,
  // loose reads and noise mixed in.
  task automatic run_phase(input int n_items);
    int target;
    int pick;
    int depth;
    target = n_sent + n_items;
    while (n_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_ctl(REQ_BEGIN);
        repeat ($urandom_range(6, 1)) send_read();
        if ($urandom_range(3) == 0) begin
          send_ctl(REQ_BEGIN);
          repeat ($urandom_range(3, 1)) send_read();
          send_ctl(REQ_END);
        end
        send_ctl(REQ_END);
        repeat ($urandom_range(4)) send_read();
      end else if (pick < 65) begin
        // Nest from four levels short of the stack depth to two past it, then unwind as far or up to two further.
        depth = $urandom_range(CP_DEPTH + 2, CP_DEPTH - 4);
        repeat (depth) begin
          send_ctl(REQ_BEGIN);
          if ($urandom_range(1)) send_read();
        end
        repeat (depth + $urandom_range(2)) begin
          send_ctl(REQ_END);
          if ($urandom_range(3) == 0) send_read();
        end
      end else if (pick < 82) begin
        repeat ($urandom_range(8, 1)) send_read();
      end else begin
        repeat ($urandom_range(4, 1))
          send_ctl(REQ_W'($urandom_range(3)));
      end
      if ($urandom_range(49) == 0) wait_drained();
    end
  endtask

  // Main sequence.
  initial begin
    rst_n               <= 1'b0;
    req_ch.valid        <= 1'b0;
    req_ch.req_type     <= REQ_READ;
    req_ch.commit       <= 1'b0;
    req_ch.source_byte  <= '0;
    req_ch.source_error <= 1'b0;
    tx_idle_pct = 20;
    rx_idle_pct = 45;
    n_sent      = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corner cases.
    send_req(REQ_READ,   1'b0, 8'h00, 1'b0);  // fresh read with no checkpoint
    send_req(REQ_READ,   1'b1, 8'hFF, 1'b0);
    send_req(REQ_READ,   1'b0, 8'h77, 1'b1);  // source failure
    send_req(REQ_END,    1'b1, 8'h00, 1'b0);  // end on an empty stack
    send_req(REQ_END,    1'b0, 8'hFF, 1'b1);
    send_req(REQ_UNUSED, 1'b1, 8'hFF, 1'b1);  // ignored request code
    send_req(REQ_BEGIN,  1'b0, 8'h00, 1'b0);
    send_req(REQ_READ,   1'b0, 8'hA5, 1'b0);  // recorded under a checkpoint
    send_req(REQ_READ,   1'b1, 8'h5A, 1'b0);
    send_req(REQ_READ,   1'b0, 8'h33, 1'b1);  // failure under a checkpoint
    send_req(REQ_BEGIN,  1'b1, 8'hFF, 1'b1);
    send_req(REQ_READ,   1'b0, 8'hFF, 1'b0);
    send_req(REQ_END,    1'b1, 8'h00, 1'b0);  // commit keeps the position
    send_req(REQ_END,    1'b0, 8'h00, 1'b0);  // rollback to the start
    send_req(REQ_READ,   1'b0, 8'h11, 1'b1);  // replay ignores the error
    send_req(REQ_READ,   1'b0, 8'h22, 1'b0);
    send_req(REQ_READ,   1'b0, 8'h44, 1'b0);
    send_req(REQ_READ,   1'b0, 8'h00, 1'b0);  // fresh again, not recorded
    send_req(REQ_BEGIN,  1'b0, 8'h00, 1'b0);
    send_req(REQ_READ,   1'b0, 8'h3C, 1'b0);
    send_req(REQ_END,    1'b1, 8'h00, 1'b0);
    wait_drained();

    // Random part under three idling profiles.
    run_phase(600);
    wait_drained();
    tx_idle_pct = 45;
    rx_idle_pct = 20;
    run_phase(600);
    wait_drained();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_phase(600);

    // Let the last results arrive, then allow for any stray extras.
    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS backtracking_byte_stream");
    end else begin
      $display("FAIL backtracking_byte_stream");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("FAIL backtracking_byte_stream");
    $finish;
  end

endmodule

FILE: files.f
design/bbs_pkg.sv
design/bbs_req_if.sv
design/bbs_rsp_if.sv
design/bbs_ctrl.sv
design/bbs_datapath.sv
design/backtracking_byte_stream.sv
design/bbs_checker.sv
tb/testbench.sv
